FILE: hw/rtl/mrhw_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers for the right-hand maze walker.
// Used by the walker top level and its port checker; no dependencies.
package mrhw_pkg;

  // Default side of the square wall grid.
  localparam int GRID_SIDE_DEF = 16;

  // Widths of the payload fields.
  localparam int POS_W   = 4;
  localparam int HD_W    = 2;
  localparam int STAT_W  = 3;
  localparam int OP_W    = 2;
  localparam int STEP_W  = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W   = 10;
  localparam int BUS_W   = 16;

  // Operations carried in the input beat's tuser.
  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_STEP    = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_LOADED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_MOVED   = 3'd1;
  localparam logic [STAT_W-1:0] ST_EXIT    = 3'd2;
  localparam logic [STAT_W-1:0] ST_TIMEOUT = 3'd3;
  localparam logic [STAT_W-1:0] ST_DONE    = 3'd4;

  // Headings.
  localparam logic [HD_W-1:0] HD_NORTH = 2'd0;
  localparam logic [HD_W-1:0] HD_EAST  = 2'd1;
  localparam logic [HD_W-1:0] HD_SOUTH = 2'd2;
  localparam logic [HD_W-1:0] HD_WEST  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_START_COL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_ROW     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_HEADING = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXIT_COL      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EXIT_ROW      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT    = 3'd5;

  // Register reset values.
  localparam logic [POS_W-1:0]  RST_START_COL     = 4'd10;
  localparam logic [POS_W-1:0]  RST_START_ROW     = 4'd4;
  localparam logic [HD_W-1:0]   RST_START_HEADING = HD_NORTH;
  localparam logic [POS_W-1:0]  RST_EXIT_COL      = 4'd0;
  localparam logic [POS_W-1:0]  RST_EXIT_ROW      = 4'd2;
  localparam logic [STEP_W-1:0] RST_STEP_LIMIT    = 10'd100;

  // A neighbouring cell, one bit wider than a position so that stepping off
  // either edge of the 0..15 range shows up as a large value.
  typedef struct packed {
    logic [POS_W:0] row;
    logic [POS_W:0] col;
  } cell_t;

  // Row decreases going north, column increases going east.
  function automatic cell_t neighbour(input logic [POS_W-1:0] row,
                                      input logic [POS_W-1:0] col,
                                      input logic [HD_W-1:0]  hd);
    cell_t nb;
    nb.row = {1'b0, row};
    nb.col = {1'b0, col};
    unique case (hd)
      HD_NORTH: nb.row = {1'b0, row} - 5'd1;
      HD_EAST:  nb.col = {1'b0, col} + 5'd1;
      HD_SOUTH: nb.row = {1'b0, row} + 5'd1;
      HD_WEST:  nb.col = {1'b0, col} - 5'd1;
      default:  nb.row = {1'b0, row};
    endcase
    return nb;
  endfunction

endpackage

FILE: hw/rtl/mrhw_ram.sv
`timescale 1ns / 1ps
// Generic RAM: one write port and two read ports, read data registered.
// No dependencies.
module mrhw_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: hw/rtl/maze_right_hand_walker.sv
`timescale 1ns / 1ps
// Right-hand wall follower over a square grid of wall bits held in a RAM.
// Depends on mrhw_pkg and mrhw_ram.
//
//   Channel   Direction  Beat contents (lowest bit first)
//   s_*       in         tdata: cell_row, cell_col, cell_is_wall; tuser: operation
//   m_*       out        tdata: pos_col, pos_row, heading, status
//   cfg_*     in         cfg_index selects a register, cfg_data is its value
//
// Each item passes two states: the accept cycle in S_IDLE, in which the grid
// RAM is read at the cells to the right and ahead of the walker, then S_EXEC,
// in which the registered read data decide the move and the result is written.
// After reset the block clears all GRID_SIDE*GRID_SIDE cells (256 at the
// default side), one cell a cycle, and takes no input beat until done.
// A result that is not taken holds the next item in S_EXEC until the output
// register is free; configuration writes are taken at any time.
module maze_right_hand_walker #(
  parameter int GRID_SIDE = mrhw_pkg::GRID_SIDE_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Input beat. tdata: cell_row [3:0], cell_col [7:4], cell_is_wall [8].
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [mrhw_pkg::BUS_W-1:0]          s_tdata,
  // tuser: operation [1:0].
  input  logic [mrhw_pkg::OP_W-1:0]           s_tuser,
  // Result beat. tdata: pos_col [3:0], pos_row [7:4], heading [9:8],
  // status [12:10].
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [mrhw_pkg::BUS_W-1:0]          m_tdata,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [mrhw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mrhw_pkg::CFG_W-1:0]          cfg_data
);

  localparam int DEPTH  = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  // The position fields are four bits wide, so a grid larger than 16 is only
  // used in its top-left 16 by 16 corner.
  localparam int LIM = (GRID_SIDE < 16) ? GRID_SIDE : 16;
  localparam logic [mrhw_pkg::POS_W:0] LIM_CELL  = (mrhw_pkg::POS_W + 1)'(LIM);
  localparam logic [ADDR_W-1:0]        LAST_ADDR = ADDR_W'(DEPTH - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [mrhw_pkg::POS_W-1:0] r,
                                                  input logic [mrhw_pkg::POS_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(GRID_SIDE) + ADDR_W'(c);
  endfunction

  // Configuration registers.
  logic [mrhw_pkg::POS_W-1:0]  start_col;
  logic [mrhw_pkg::POS_W-1:0]  start_row;
  logic [mrhw_pkg::HD_W-1:0]   start_heading;
  logic [mrhw_pkg::POS_W-1:0]  exit_col;
  logic [mrhw_pkg::POS_W-1:0]  exit_row;
  logic [mrhw_pkg::STEP_W-1:0] step_limit;

  // Walker state.
  state_t                      state;
  logic [ADDR_W-1:0]           clr_addr;
  logic [mrhw_pkg::OP_W-1:0]   op;
  logic [mrhw_pkg::POS_W-1:0]  cur_col;
  logic [mrhw_pkg::POS_W-1:0]  cur_row;
  logic [mrhw_pkg::HD_W-1:0]   cur_heading;
  logic [mrhw_pkg::STEP_W-1:0] steps_taken;
  logic                        walk_done;

  logic [mrhw_pkg::POS_W-1:0]  cur_col_next;
  logic [mrhw_pkg::POS_W-1:0]  cur_row_next;
  logic [mrhw_pkg::HD_W-1:0]   cur_heading_next;
  logic [mrhw_pkg::STEP_W-1:0] steps_taken_next;
  logic                        walk_done_next;
  logic [mrhw_pkg::STAT_W-1:0] status_next;

  // Input decode.
  logic [mrhw_pkg::POS_W-1:0]  in_row;
  logic [mrhw_pkg::POS_W-1:0]  in_col;
  logic                        in_wall;
  logic                        accept;
  logic                        load_hit;

  // Neighbour lookup.
  logic [mrhw_pkg::HD_W-1:0]   hd_right;
  logic [mrhw_pkg::HD_W-1:0]   hd_left;
  mrhw_pkg::cell_t             nb_right;
  mrhw_pkg::cell_t             nb_ahead;
  logic                        right_in_grid;
  logic                        ahead_in_grid;
  logic                        right_open;
  logic                        ahead_open;
  logic [mrhw_pkg::STEP_W-1:0] steps_inc;

  // Grid RAM ports.
  logic                        ram_we;
  logic [ADDR_W-1:0]           ram_waddr;
  logic                        ram_wdata;
  logic [ADDR_W-1:0]           ram_raddr_a;
  logic [ADDR_W-1:0]           ram_raddr_b;
  logic                        ram_rdata_a;
  logic                        ram_rdata_b;

  assign in_row  = s_tdata[3:0];
  assign in_col  = s_tdata[7:4];
  assign in_wall = s_tdata[8];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // A load outside the usable grid writes nothing but still reports.
  assign load_hit = accept && (s_tuser == mrhw_pkg::OP_LOAD) &&
                    ({1'b0, in_row} < LIM_CELL) && ({1'b0, in_col} < LIM_CELL);

  // The clearing pass and loads share the single write port; they never
  // overlap because no beat is accepted while clearing.
  assign ram_we    = (state == S_CLEAR) || load_hit;
  assign ram_waddr = (state == S_CLEAR) ? clr_addr : cell_addr(in_row, in_col);
  assign ram_wdata = (state == S_CLEAR) ? 1'b0 : in_wall;

  // The read addresses follow the walker state, which stays put between the
  // accept edge and the execute cycle, so the registered read data seen in
  // S_EXEC belong to the cells around the current position.
  assign hd_right = cur_heading + 2'd1;
  assign hd_left  = cur_heading - 2'd1;
  assign nb_right = mrhw_pkg::neighbour(cur_row, cur_col, hd_right);
  assign nb_ahead = mrhw_pkg::neighbour(cur_row, cur_col, cur_heading);

  // Off-grid neighbours count as walls; both edges of the range appear as
  // values at or above the limit thanks to the extra top bit.
  assign right_in_grid = (nb_right.row < LIM_CELL) && (nb_right.col < LIM_CELL);
  assign ahead_in_grid = (nb_ahead.row < LIM_CELL) && (nb_ahead.col < LIM_CELL);

  assign ram_raddr_a = right_in_grid ?
                       cell_addr(nb_right.row[3:0], nb_right.col[3:0]) : '0;
  assign ram_raddr_b = ahead_in_grid ?
                       cell_addr(nb_ahead.row[3:0], nb_ahead.col[3:0]) : '0;

  assign right_open = right_in_grid && !ram_rdata_a;
  assign ahead_open = ahead_in_grid && !ram_rdata_b;

  // The step counter saturates at its top value.
  assign steps_inc = (steps_taken != '1) ? steps_taken + 1'b1 : steps_taken;

  mrhw_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  // Work out the effect of the pending item.
  always_comb begin
    cur_col_next     = cur_col;
    cur_row_next     = cur_row;
    cur_heading_next = cur_heading;
    steps_taken_next = steps_taken;
    walk_done_next   = walk_done;
    status_next      = mrhw_pkg::ST_LOADED;
    unique case (op)
      mrhw_pkg::OP_STEP: begin
        if (walk_done) begin
          status_next = mrhw_pkg::ST_DONE;
        end else begin
          steps_taken_next = steps_inc;
          if (steps_inc > step_limit) begin
            status_next = mrhw_pkg::ST_TIMEOUT;
          end else begin
            priority if (right_open) begin
              cur_heading_next = hd_right;
              cur_row_next     = nb_right.row[3:0];
              cur_col_next     = nb_right.col[3:0];
            end else if (ahead_open) begin
              cur_row_next     = nb_ahead.row[3:0];
              cur_col_next     = nb_ahead.col[3:0];
            end else begin
              cur_heading_next = hd_left;
            end
            // The exit is only checked after a move or turn; a walk that begins on the
            // exit cell ends at a first turn in place, else carries on until it comes back.
            if (cur_col_next == exit_col && cur_row_next == exit_row) begin
              walk_done_next = 1'b1;
              status_next    = mrhw_pkg::ST_EXIT;
            end else begin
              status_next    = mrhw_pkg::ST_MOVED;
            end
          end
        end
      end
      mrhw_pkg::OP_RESTART: begin
        cur_col_next     = start_col;
        cur_row_next     = start_row;
        cur_heading_next = start_heading;
        steps_taken_next = '0;
        walk_done_next   = 1'b0;
      end
      default: begin
        // Loads were written at the accept edge; the unused code does nothing.
        status_next = mrhw_pkg::ST_LOADED;
      end
    endcase
  end

  // Sequencer, walker state and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      op          <= mrhw_pkg::OP_LOAD;
      cur_col     <= mrhw_pkg::RST_START_COL;
      cur_row     <= mrhw_pkg::RST_START_ROW;
      cur_heading <= mrhw_pkg::RST_START_HEADING;
      steps_taken <= '0;
      walk_done   <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      // In S_EXEC a taken result is replaced by the new one below.
      if (m_tvalid && m_tready && (state != S_EXEC)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            op    <= s_tuser;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (!m_tvalid || m_tready) begin
            cur_col     <= cur_col_next;
            cur_row     <= cur_row_next;
            cur_heading <= cur_heading_next;
            steps_taken <= steps_taken_next;
            walk_done   <= walk_done_next;
            m_tvalid    <= 1'b1;
            m_tdata     <= {3'b000, status_next, cur_heading_next,
                            cur_row_next, cur_col_next};
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  // Configuration registers. Start values take effect at the next restart,
  // the exit cell and the step limit at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_col     <= mrhw_pkg::RST_START_COL;
      start_row     <= mrhw_pkg::RST_START_ROW;
      start_heading <= mrhw_pkg::RST_START_HEADING;
      exit_col      <= mrhw_pkg::RST_EXIT_COL;
      exit_row      <= mrhw_pkg::RST_EXIT_ROW;
      step_limit    <= mrhw_pkg::RST_STEP_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mrhw_pkg::REG_START_COL:     start_col     <= cfg_data[3:0];
        mrhw_pkg::REG_START_ROW:     start_row     <= cfg_data[3:0];
        mrhw_pkg::REG_START_HEADING: start_heading <= cfg_data[1:0];
        mrhw_pkg::REG_EXIT_COL:      exit_col      <= cfg_data[3:0];
        mrhw_pkg::REG_EXIT_ROW:      exit_row      <= cfg_data[3:0];
        mrhw_pkg::REG_STEP_LIMIT:    step_limit    <= cfg_data;
        default: begin
          step_limit <= step_limit;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/mrhw_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the right-hand maze walker, bound to its top level.
// Depends on mrhw_pkg.
module mrhw_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [mrhw_pkg::BUS_W-1:0]   m_tdata
);

  // Items are worked one at a time: no beat is taken right after another.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input beat accepted in the cycle after another");

  // A fresh result is raised from S_EXEC, which the walker enters when its
  // item is taken; the check looks back for that accepting edge.
  a_result_follows_item: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result beat without a matching input beat");

  // Only the defined status codes reach the output.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[12:10] <= mrhw_pkg::ST_DONE))
    else $error("undefined status code on the result beat");

  // A stalled result is held.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result beat changed or dropped");

endmodule

bind maze_right_hand_walker mrhw_checker u_mrhw_checker (.*);
